### design/indexed_list_store_core_macros.svh
// Assertion helpers for the checker file.
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ILS_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ILS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W    = 3;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 5;

  // Operation codes; codes above OP_DELETE are unknown and rejected.
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  // Read value returned when nothing was read.
  localparam logic signed [VALUE_W-1:0] NOT_READ = '1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_t                   status;
    logic [LEN_W-1:0]          length;
  } rsp_t;

endpackage

### design/indexed_list_store_core.sv
`timescale 1ns / 1ps

// Indexed list store: an ordered list of up to CAPACITY signed 32-bit values.
// Request channel (req_valid/req_ready/req): one operation per transaction,
// read, insert at head, insert at tail, insert at index, or delete at index.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one transaction per
// request, in order, carrying the read value (-1 if nothing was read), a
// status (done, index out of range, store full) and the length afterwards.
// Pipeline: an accepted request is held in the input register, then its
// result lands in the response register once that register is free or drained.
// Throughput: one request per cycle while the response side is not stalled.
// The whole cell row shifts or is selected in parallel between the two registers.
// Stall: while rsp_ready is low the response holds, the input register keeps
// its request, and req_ready drops only once both registers are occupied.
// Reset (rst, synchronous): the list becomes empty and both registers empty;
// stored cell contents are not cleared, since only entries below the length
// are ever read.

module indexed_list_store_core #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ils_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ils_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;

  // Input register
  logic          req_q_valid;
  ils_pkg::req_t req_q;
  logic          advance;

  // List state
  logic signed [ils_pkg::VALUE_W-1:0] cells      [CAPACITY];
  logic signed [ils_pkg::VALUE_W-1:0] cells_next [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Decode of the request in the input register
  logic [CMP_W-1:0]                   pos_c;
  logic [CMP_W-1:0]                   cnt_c;
  logic [CMP_W-1:0]                   edit_pos;
  logic                               full;
  logic                               do_ins;
  logic                               do_del;
  logic signed [ils_pkg::VALUE_W-1:0] rv;
  ils_pkg::status_t                   st;

  // The input register moves on when the response register is free or
  // being drained this cycle.
  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  assign pos_c = CMP_W'(req_q.position);
  assign cnt_c = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));

  always_comb begin
    rv       = ils_pkg::NOT_READ;
    st       = ils_pkg::ST_DONE;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    edit_pos = pos_c;
    case (req_q.operation)
      ils_pkg::OP_READ: begin
        if (pos_c < cnt_c) begin
          rv = cells[req_q.position[IDX_W-1:0]];
        end else begin
          st = ils_pkg::ST_RANGE;
        end
      end
      ils_pkg::OP_INS_HEAD: begin
        edit_pos = '0;
        if (full) begin
          st = ils_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ils_pkg::OP_INS_TAIL: begin
        edit_pos = cnt_c;
        if (full) begin
          st = ils_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ils_pkg::OP_INS_AT: begin
        // Range is checked before fullness.
        if (pos_c > cnt_c) begin
          st = ils_pkg::ST_RANGE;
        end else if (full) begin
          st = ils_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ils_pkg::OP_DELETE: begin
        if (pos_c < cnt_c) begin
          do_del = 1'b1;
        end else begin
          st = ils_pkg::ST_RANGE;
        end
      end
      default: begin
        st = ils_pkg::ST_RANGE;
      end
    endcase
  end

  // Each cell picks its next value from itself, its lower or upper
  // neighbor, or the new value. Cells past the length take junk harmlessly.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cells_next[i] = cells[i];
      if (do_ins) begin
        if (CMP_W'(i) == edit_pos) begin
          cells_next[i] = req_q.value;
        end else if (CMP_W'(i) > edit_pos) begin
          if (i > 0) begin
            cells_next[i] = cells[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (do_del) begin
        if (CMP_W'(i) >= edit_pos) begin
          if (i < CAPACITY - 1) begin
            cells_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= count_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= advance || (rsp_valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.read_value <= rv;
      rsp.status     <= st;
      rsp.length     <= ils_pkg::LEN_W'(count_next);
    end
  end

endmodule

### design/ils_checker.sv
`timescale 1ns / 1ps
`include "indexed_list_store_core_macros.svh"

module ils_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ils_pkg::rsp_t rsp
);

  // A stalled response holds.
  `ILS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

  // Request side only backs up when the response side is stalled.
  `ILS_ASSERT(a_ready_only_stall, clk, rst, !req_ready, rsp_valid && !rsp_ready, "req_ready low without a response stall")

  // A refused insert never carries a read value.
  `ILS_ASSERT(a_full_no_read, clk, rst, rsp_valid && rsp.status == ils_pkg::ST_FULL, rsp.read_value == ils_pkg::NOT_READ, "full status with a read value")

  // Reset empties the response register.
  `ILS_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !rsp_valid, "response valid after reset")

  // Status is always one of the three defined codes.
  `ILS_ASSERT(a_status_code, clk, rst, rsp_valid, rsp.status == ils_pkg::ST_DONE || rsp.status == ils_pkg::ST_RANGE || rsp.status == ils_pkg::ST_FULL, "illegal status code")

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

### verif/indexed_list_store_core_test.sv
`timescale 1ns / 1ps

module indexed_list_store_core_test;

  localparam int CAP = ils_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_CHUNKS = 14;
  localparam int CHUNK_ITEMS = 100;

  // Unknown operation codes: everything past delete.
  localparam logic [ils_pkg::OP_W-1:0] OP_BAD_FIRST = ils_pkg::OP_DELETE + 3'd1;
  localparam logic [ils_pkg::OP_W-1:0] OP_BAD_LAST  = '1;

  typedef struct {
    ils_pkg::req_t item;
    int            reps;   // times the row is sent, value stepping by one
    bit            typed;  // want holds the answer; otherwise the list model decides
    ils_pkg::rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ils_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ils_pkg::rsp_t rsp;

  // Software copy of the list, head at index 0.
  logic signed [ils_pkg::VALUE_W-1:0] list_vals[$];
  ils_pkg::rsp_t replies_due[$];
  plan_row_t plan[$];

  int idle_pct = 0;
  int rsp_hold = 0;
  int errors = 0;
  int cycles = 0;

  indexed_list_store_core uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one operation to the list copy and returns the transaction the
  // block must answer with.
  function automatic ils_pkg::rsp_t apply_list_op(ils_pkg::req_t r);
    ils_pkg::rsp_t o;
    int p;
    bit full;
    o.read_value = ils_pkg::NOT_READ;
    o.status = ils_pkg::ST_DONE;
    p = int'(r.position);
    full = list_vals.size() >= CAP;
    case (r.operation)
      ils_pkg::OP_READ: begin
        if (p < list_vals.size()) o.read_value = list_vals[p];
        else o.status = ils_pkg::ST_RANGE;
      end
      ils_pkg::OP_INS_HEAD: begin
        if (full) o.status = ils_pkg::ST_FULL;
        else list_vals.push_front(r.value);
      end
      ils_pkg::OP_INS_TAIL: begin
        if (full) o.status = ils_pkg::ST_FULL;
        else list_vals.push_back(r.value);
      end
      ils_pkg::OP_INS_AT: begin
        // index check wins over the full check
        if (p > list_vals.size()) o.status = ils_pkg::ST_RANGE;
        else if (full) o.status = ils_pkg::ST_FULL;
        else list_vals.insert(p, r.value);
      end
      ils_pkg::OP_DELETE: begin
        if (p < list_vals.size()) list_vals.delete(p);
        else o.status = ils_pkg::ST_RANGE;
      end
      default: o.status = ils_pkg::ST_RANGE;
    endcase
    o.length = ils_pkg::LEN_W'(list_vals.size());
    return o;
  endfunction

  function automatic plan_row_t row(logic [ils_pkg::OP_W-1:0] op, int pos,
                                    logic [ils_pkg::VALUE_W-1:0] val,
                                    int reps, bit typed, logic [ils_pkg::VALUE_W-1:0] rv,
                                    ils_pkg::status_t st, int len);
    plan_row_t t;
    t.item.operation = op;
    t.item.position = ils_pkg::POS_W'(pos);
    t.item.value = val;
    t.reps = reps;
    t.typed = typed;
    t.want.read_value = rv;
    t.want.status = st;
    t.want.length = ils_pkg::LEN_W'(len);
    return t;
  endfunction

  // Random operation; ins_bias is the percentage of inserts, which steers
  // the list toward full or toward empty.
  function automatic ils_pkg::req_t pick_item(int ins_bias);
    ils_pkg::req_t r;
    int k;
    r.value = $urandom;
    if ($urandom_range(0, 3) == 0) r.position = ils_pkg::POS_W'($urandom_range(0, 255));
    else r.position = ils_pkg::POS_W'($urandom_range(0, list_vals.size() + 1));
    k = $urandom_range(0, 99);
    if (k < 3) begin
      r.operation = ils_pkg::OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
    end else if (k < 3 + ins_bias) begin
      r.operation = ils_pkg::OP_W'($urandom_range(ils_pkg::OP_INS_HEAD, ils_pkg::OP_INS_AT));
    end else if ($urandom_range(0, 1) == 1) begin
      r.operation = ils_pkg::OP_READ;
    end else begin
      r.operation = ils_pkg::OP_DELETE;
    end
    return r;
  endfunction

  // Holds the transaction until accepted, then logs what should come back.
  // Valid is left high; the caller lowers it only for a gap or a drain.
  task automatic send_one(input ils_pkg::req_t item, input bit typed,
                          input ils_pkg::rsp_t want);
    ils_pkg::rsp_t got;
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    got = apply_list_op(item);
    replies_due.push_back(typed ? want : got);
  endtask

  task automatic maybe_gap();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    errors++;
  endtask

  // Response side: stalls rsp_ready in random bursts, checks in order.
  always @(posedge clk) begin : rsp_side
    ils_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_hold <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none got %h", $time, rsp);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (rsp.read_value !== want.read_value)
            report_field("read_value", want.read_value, rsp.read_value);
          if (rsp.status !== want.status)
            report_field("status", want.status, rsp.status);
          if (rsp.length !== want.length)
            report_field("length", want.length, rsp.length);
        end
      end
      if (rsp_hold != 0) begin
        rsp_ready <= 1'b0;
        rsp_hold <= rsp_hold - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        rsp_ready <= 1'b0;
        rsp_hold <= $urandom_range(0, 3);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    ils_pkg::req_t item;
    int bias;
    // Empty store: every indexed access is out of range, unknown codes too.
    plan.push_back(row(ils_pkg::OP_READ, 0, 0, 1, 1, ils_pkg::NOT_READ, ils_pkg::ST_RANGE, 0));
    plan.push_back(row(ils_pkg::OP_DELETE, 0, 0, 1, 1, ils_pkg::NOT_READ, ils_pkg::ST_RANGE, 0));
    plan.push_back(row(ils_pkg::OP_INS_AT, 1, 0, 1, 1, ils_pkg::NOT_READ, ils_pkg::ST_RANGE, 0));
    plan.push_back(row(OP_BAD_FIRST, 0, 0, 1, 1, ils_pkg::NOT_READ, ils_pkg::ST_RANGE, 0));
    plan.push_back(row(OP_BAD_LAST, 255, 32'hFFFF_FFFF, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_RANGE, 0));
    // Extreme values at head, tail and middle; tail ignores position.
    plan.push_back(row(ils_pkg::OP_INS_HEAD, 0, 32'h7FFF_FFFF, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_DONE, 1));
    plan.push_back(row(ils_pkg::OP_INS_TAIL, 255, 32'h8000_0000, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_DONE, 2));
    plan.push_back(row(ils_pkg::OP_INS_AT, 1, 0, 1, 1, ils_pkg::NOT_READ, ils_pkg::ST_DONE, 3));
    plan.push_back(row(ils_pkg::OP_READ, 0, 0, 1, 1, 32'h7FFF_FFFF, ils_pkg::ST_DONE, 3));
    plan.push_back(row(ils_pkg::OP_READ, 2, 0, 1, 1, 32'h8000_0000, ils_pkg::ST_DONE, 3));
    plan.push_back(row(ils_pkg::OP_READ, 255, 0, 1, 1, ils_pkg::NOT_READ, ils_pkg::ST_RANGE, 3));
    // Fill to capacity, then every insert flavor against a full store.
    plan.push_back(row(ils_pkg::OP_INS_TAIL, 0, 32'h0000_1000, CAP - 3, 0, ils_pkg::NOT_READ,
                       ils_pkg::ST_DONE, 0));
    plan.push_back(row(ils_pkg::OP_INS_HEAD, 0, 32'hFFFF_FFFF, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_FULL, CAP));
    plan.push_back(row(ils_pkg::OP_INS_TAIL, 0, 32'h1234_5678, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_FULL, CAP));
    plan.push_back(row(ils_pkg::OP_INS_AT, CAP, 32'h1, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_FULL, CAP));
    // Index past the end is reported ahead of full.
    plan.push_back(row(ils_pkg::OP_INS_AT, CAP + 1, 32'h1, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_RANGE, CAP));
    plan.push_back(row(ils_pkg::OP_READ, CAP - 1, 0, 1, 0, ils_pkg::NOT_READ,
                       ils_pkg::ST_DONE, 0));
    plan.push_back(row(ils_pkg::OP_READ, CAP, 0, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_RANGE, CAP));
    plan.push_back(row(ils_pkg::OP_DELETE, CAP - 1, 0, 1, 0, ils_pkg::NOT_READ,
                       ils_pkg::ST_DONE, 0));
    plan.push_back(row(ils_pkg::OP_DELETE, 0, 0, 1, 0, ils_pkg::NOT_READ, ils_pkg::ST_DONE, 0));
    plan.push_back(row(ils_pkg::OP_DELETE, 255, 0, 1, 1, ils_pkg::NOT_READ,
                       ils_pkg::ST_RANGE, CAP - 2));
    // Insert at index equal to the length appends.
    plan.push_back(row(ils_pkg::OP_INS_AT, CAP - 2, 32'h5555_AAAA, 1, 0, ils_pkg::NOT_READ,
                       ils_pkg::ST_DONE, 0));
    plan.push_back(row(ils_pkg::OP_READ, CAP - 2, 0, 1, 0, ils_pkg::NOT_READ,
                       ils_pkg::ST_DONE, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        item = plan[i].item;
        item.value = item.value + k;
        send_one(item, plan[i].typed, plan[i].want);
        maybe_gap();
      end
    end

    // Let the pipeline empty completely before the random part.
    drain();

    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      // Alternate filling and draining so full and empty are both visited.
      bias = (chunk % 2 == 0) ? 60 : 20;
      if (chunk >= RANDOM_CHUNKS - 2) idle_pct = 0;
      else idle_pct = 15 * $urandom_range(0, 2);
      if (chunk == RANDOM_CHUNKS / 2) drain();
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        send_one(pick_item(bias), 0, '0);
        maybe_gap();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ils_pkg.sv
design/indexed_list_store_core.sv
design/ils_checker.sv
verif/indexed_list_store_core_test.sv
